FILE: hw/rtl/rxla_pkg.sv
// Shared types and constants for the receive line assembler.
package rxla_pkg;

  // Operation codes carried on the input tuser
  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_READ = 2'd1,
    OP_SNAP = 2'd2
  } op_t;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  localparam int LW_W  = 4;   // lines_waiting field width
  localparam int CTR_W = 32;  // drop counter width
  localparam int OUT_DATA_W = 112;

  // One result as it travels down the pipeline
  typedef struct packed {
    logic             status;
    logic             use_mem;
    logic             eol;
    logic [LW_W-1:0]  lines_waiting;
    logic [CTR_W-1:0] ovf_drops;
    logic [CTR_W-1:0] full_drops;
    logic [CTR_W-1:0] total_drops;
  } res_t;

endpackage

FILE: hw/rtl/rx_line_assembler_fifo_top.sv
// Receive line assembler: byte stream in, queued lines read out a character at a time.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+--------------------------------------------
//  in_     | in  | in_tvalid / in_tready  | tuser op, tdata rx_byte, tlast last_of_chunk
//  out_    | out | out_tvalid / out_tready| tuser status, tdata char/count/drops,
//          |     |                        | tlast end_of_line
//
// Cycles: one transfer per clock while out_tready is high; each result is held in the read
// stage, then the output register. Single line store: one write, one registered read a cycle.
// Reset: rst_n synchronous, active low; clears pointers, counts and the pipeline, while
// the line store and length table are left as they are, so no clearing pass is needed.
// Stalls: the read stage and the output register hold two results between them, so
// in_tready stays high while the output is held as long as the read stage is free.
module rx_line_assembler_fifo_top
  import rxla_pkg::*;
#(
  parameter int LINE_MAX    = 160,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] rx_byte
  input  logic [1:0]            in_tuser,   // [1:0] operation
  input  logic                  in_tlast,   // last_of_chunk, no effect on assembly
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [7:0] line_char, [11:8] lines_waiting,
                                            // [43:12] overflow_drops,
                                            // [75:44] queue_full_drops,
                                            // [107:76] total_drops, rest zero
  output logic                  out_tuser,  // status
  output logic                  out_tlast   // end_of_line
);

  localparam int SLOT_COUNT = QUEUE_DEPTH + 1;
  localparam int MEM_DEPTH  = SLOT_COUNT * LINE_MAX;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int LEN_W      = $clog2(LINE_MAX + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);
  localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'((SLOT_COUNT - 1) * LINE_MAX);
  localparam logic [ADDR_W-1:0] SLOT_STEP = ADDR_W'(LINE_MAX);
  localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(LINE_MAX);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(QUEUE_DEPTH);

  // Line store, one slot of LINE_MAX bytes per queue entry plus the assembly slot
  logic [7:0]       line_mem [MEM_DEPTH];
  logic [LEN_W-1:0] len_r    [SLOT_COUNT];

  // Control state
  logic [SLOT_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [ADDR_W-1:0] head_base_r, head_base_nxt, tail_base_r, tail_base_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [LEN_W-1:0]  rpos_r, rpos_nxt, alen_r, alen_nxt;
  logic              ovfl_r, ovfl_nxt;
  logic [CTR_W-1:0]  ovf_cnt_r, ovf_cnt_nxt, full_cnt_r, full_cnt_nxt;
  logic [CTR_W-1:0]  total_r, total_nxt;

  // Memory access
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, rdata_r;
  logic              len_we;

  // Pipeline: read stage then output register
  logic       p_valid_r, p_valid_nxt, p_move;
  res_t       p_res_r, res_new;
  logic       out_valid_r, out_valid_nxt;
  res_t       out_res_r;
  logic [7:0] out_char_r;

  logic       accept;
  logic [1:0] op;
  logic [7:0] rx_byte;

  assign op      = in_tuser;
  assign rx_byte = in_tdata;

  assign p_move    = p_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !p_valid_r || p_move;
  assign accept    = in_tvalid && in_tready;

  // Step the line state for one accepted transfer
  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    head_base_nxt = head_base_r;
    tail_base_nxt = tail_base_r;
    count_nxt     = count_r;
    rpos_nxt      = rpos_r;
    alen_nxt      = alen_r;
    ovfl_nxt      = ovfl_r;
    ovf_cnt_nxt   = ovf_cnt_r;
    full_cnt_nxt  = full_cnt_r;
    total_nxt     = total_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = tail_base_r + ADDR_W'(alen_r);
    mem_raddr     = head_base_r + ADDR_W'(rpos_r);
    mem_wdata     = rx_byte;
    len_we        = 1'b0;
    res_new       = '0;

    if (accept) begin
      unique case (op)
        OP_PUSH: begin
          if (rx_byte == CH_LF) begin
            if (ovfl_r) begin
              total_nxt   = total_r + 1'b1;
              ovf_cnt_nxt = ovf_cnt_r + 1'b1;
            end else if (count_r < CNT_MAX) begin
              // Commit the assembly slot as a queued line
              len_we        = 1'b1;
              tail_nxt      = (tail_r == LAST_SLOT) ? '0 : tail_r + 1'b1;
              tail_base_nxt = (tail_base_r == LAST_BASE) ? '0 : tail_base_r + SLOT_STEP;
              count_nxt     = count_r + 1'b1;
            end else begin
              total_nxt    = total_r + 1'b1;
              full_cnt_nxt = full_cnt_r + 1'b1;
            end
            alen_nxt = '0;
            ovfl_nxt = 1'b0;
          end else if (rx_byte == CH_CR) begin
            // skip carriage return
          end else if (!ovfl_r) begin
            if (alen_r < LEN_MAX) begin
              mem_we   = 1'b1;
              alen_nxt = alen_r + 1'b1;
            end else begin
              ovfl_nxt = 1'b1;
            end
          end
        end
        OP_READ: begin
          if (count_r == '0) begin
            res_new.status = 1'b1;
          end else if (rpos_r < len_r[head_r]) begin
            mem_re          = 1'b1;
            res_new.use_mem = 1'b1;
            rpos_nxt        = rpos_r + 1'b1;
          end else begin
            // Terminator: pop the head line
            res_new.eol   = 1'b1;
            head_nxt      = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
            head_base_nxt = (head_base_r == LAST_BASE) ? '0 : head_base_r + SLOT_STEP;
            count_nxt     = count_r - 1'b1;
            rpos_nxt      = '0;
          end
        end
        OP_SNAP: begin
          ovf_cnt_nxt  = '0;
          full_cnt_nxt = '0;
        end
        default: begin
          // unused code: report only
        end
      endcase
    end

    res_new.lines_waiting = LW_W'(count_nxt);
    // Report counters after the push but before a snapshot clear
    res_new.ovf_drops   = (op == OP_SNAP) ? ovf_cnt_r  : ovf_cnt_nxt;
    res_new.full_drops  = (op == OP_SNAP) ? full_cnt_r : full_cnt_nxt;
    res_new.total_drops = total_nxt;
  end

  always_comb begin
    p_valid_nxt = p_valid_r;
    if (accept) begin
      p_valid_nxt = 1'b1;
    end else if (p_move) begin
      p_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (p_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Line store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= line_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_r[tail_r] <= alen_r;
    end
    if (accept) begin
      p_res_r <= res_new;
    end
    if (p_move) begin
      out_res_r  <= p_res_r;
      out_char_r <= p_res_r.use_mem ? rdata_r : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      head_base_r <= '0;
      tail_base_r <= '0;
      count_r     <= '0;
      rpos_r      <= '0;
      alen_r      <= '0;
      ovfl_r      <= 1'b0;
      ovf_cnt_r   <= '0;
      full_cnt_r  <= '0;
      total_r     <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      head_base_r <= head_base_nxt;
      tail_base_r <= tail_base_nxt;
      count_r     <= count_nxt;
      rpos_r      <= rpos_nxt;
      alen_r      <= alen_nxt;
      ovfl_r      <= ovfl_nxt;
      ovf_cnt_r   <= ovf_cnt_nxt;
      full_cnt_r  <= full_cnt_nxt;
      total_r     <= total_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tlast  = out_res_r.eol;
  assign out_tdata  = {4'h0,
                       out_res_r.total_drops,
                       out_res_r.full_drops,
                       out_res_r.ovf_drops,
                       out_res_r.lines_waiting,
                       out_char_r};

endmodule
